// ===== hdl/bssd_pkg.sv =====
`default_nettype none
package bssd_pkg;

    localparam int MAX_DIM    = 64;
    localparam int COORD_W    = 6;
    localparam int SIZE_W     = 7;
    localparam int RADIUS_W   = 5;
    localparam int PIXEL_W    = 32;
    localparam int ADDR_W     = 2 * COORD_W;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int DIST_W     = 18;
    localparam int BEST_W     = 20;
    localparam int SUM_W      = 28;
    localparam int CNT_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 4;
    localparam logic [BEST_W-1:0] START_BEST = BEST_W'(1000000);

    typedef enum logic [1:0] {
        ACT_LOAD_SRC = 2'd0,
        ACT_LOAD_TGT = 2'd1,
        ACT_DISTANCE = 2'd2,
        ACT_SEARCH   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_W  = 3'd0,
        REG_SRC_H  = 3'd1,
        REG_TGT_W  = 3'd2,
        REG_TGT_H  = 3'd3,
        REG_RADIUS = 3'd4,
        REG_MODE   = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_DRAIN,
        S_DIV,
        S_EVAL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic we_src;
        logic we_tgt;
        logic capture;
        logic win_step;
        logic div_step;
        logic eval;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_err;
        logic win_last;
        logic div_done;
        logic scan_done;
        logic out_free;
    } status_t;

    // size register as used: 0 acts as 1, above MAX_DIM acts as MAX_DIM
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = SIZE_W'(1);
            end
            else if (v > SIZE_W'(MAX_DIM))
            begin
                r = SIZE_W'(MAX_DIM);
            end
            return r;
        end
    endfunction

    function automatic logic signed [8:0] mirror_coord(input logic signed [8:0] c,
                                                      input logic [SIZE_W-1:0] w);
        logic signed [8:0] ws;
        logic signed [8:0] r;
        begin
            ws = $signed({2'b00, w});
            r  = c;
            if (c < 0)
            begin
                r = -c;
            end
            else if (c >= ws)
            begin
                r = 9'sd2 * (ws - 9'sd1) - c;
            end
            return r;
        end
    endfunction

    function automatic logic signed [8:0] wrap_coord(input logic signed [8:0] c,
                                                    input logic [SIZE_W-1:0] w);
        logic signed [8:0] ws;
        logic signed [8:0] r;
        begin
            ws = $signed({2'b00, w});
            r  = c;
            if (c < 0)
            begin
                r = c + ws;
            end
            else if (c >= ws)
            begin
                r = c - ws;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bssd_ram.sv =====
`default_nettype none
module bssd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/bssd_ctrl.sv =====
`default_nettype none
module bssd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        action,
    input  wire bssd_pkg::status_t status,
    output bssd_pkg::cmd_t         cmd
);
    import bssd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (action_t'(action))
                        ACT_LOAD_SRC: cmd.we_src = 1'b1;
                        ACT_LOAD_TGT: cmd.we_tgt = 1'b1;
                        default:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = status.in_err ? S_OUT : S_WIN;
                        end
                    endcase
                end
            end
            S_WIN:
            begin
                cmd.win_step = 1'b1;
                if (status.win_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.scan_done ? S_OUT : S_WIN;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/bssd_dp.sv =====
`default_nettype none
module bssd_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bssd_pkg::cmd_t                    cmd,
    output bssd_pkg::status_t                      status,
    input  wire logic [1:0]                        action,
    input  wire logic [bssd_pkg::COORD_W-1:0]      source_x,
    input  wire logic [bssd_pkg::COORD_W-1:0]      source_y,
    input  wire logic [bssd_pkg::COORD_W-1:0]      target_x,
    input  wire logic [bssd_pkg::COORD_W-1:0]      target_y,
    input  wire logic [bssd_pkg::PIXEL_W-1:0]      pixel,
    input  wire logic                              cfg_we,
    input  wire logic [bssd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bssd_pkg::SIZE_W-1:0]       cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [bssd_pkg::DIST_W-1:0]            distance,
    output logic [bssd_pkg::COORD_W-1:0]           match_x,
    output logic [bssd_pkg::COORD_W-1:0]           match_y,
    output logic                                   point_error
);
    import bssd_pkg::*;

    // configuration
    logic [SIZE_W-1:0]   src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic                mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= SIZE_W'(32);
            src_h_reg  <= SIZE_W'(32);
            tgt_w_reg  <= SIZE_W'(32);
            tgt_h_reg  <= SIZE_W'(32);
            radius_reg <= RADIUS_W'(2);
            mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SRC_W:  src_w_reg  <= cfg_data;
                REG_SRC_H:  src_h_reg  <= cfg_data;
                REG_TGT_W:  tgt_w_reg  <= cfg_data;
                REG_TGT_H:  tgt_h_reg  <= cfg_data;
                REG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_MODE:   mode_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    logic [SIZE_W-1:0] sw, sh, tw, th;
    assign sw = eff_size(src_w_reg);
    assign sh = eff_size(src_h_reg);
    assign tw = eff_size(tgt_w_reg);
    assign th = eff_size(tgt_h_reg);

    logic tgt_ok, src_ok, is_search;
    assign tgt_ok    = ({1'b0, target_x} < tw) && ({1'b0, target_y} < th);
    assign src_ok    = ({1'b0, source_x} < sw) && ({1'b0, source_y} < sh);
    assign is_search = (action_t'(action) == ACT_SEARCH);

    // scan step max(1, (2r+1)/4)
    logic [STEP_W-1:0] step_raw, step;
    assign step_raw = STEP_W'(({radius_reg, 1'b1}) >> 2);
    assign step     = (step_raw == '0) ? STEP_W'(1) : step_raw;

    // query and scan position
    logic [COORD_W-1:0]  tx_reg, ty_reg, px_reg, py_reg, bx_reg, by_reg;
    logic                search_reg, err_reg;
    logic [BEST_W-1:0]   best_reg;

    // window walk
    logic signed [COORD_W-1:0] dx_reg, dy_reg;
    logic signed [COORD_W-1:0] r_s;
    logic                      v1_reg;
    logic [SUM_W-1:0]          sum_reg [4];
    logic [CNT_W-1:0]          cnt_reg;

    // divider
    logic [1:0]        chan_reg;
    logic [4:0]        bit_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [BEST_W-1:0] total_reg;

    assign r_s = $signed({1'b0, radius_reg});

    logic signed [8:0] cax, cay, cbx, cby, ax, ay, bx, by;
    logic              pair_ok;
    logic [ADDR_W-1:0] src_raddr, tgt_raddr;

    always_comb
    begin
        cax = $signed({3'b000, px_reg}) + 9'(dx_reg);
        cay = $signed({3'b000, py_reg}) + 9'(dy_reg);
        cbx = $signed({3'b000, tx_reg}) + 9'(dx_reg);
        cby = $signed({3'b000, ty_reg}) + 9'(dy_reg);
        ax  = mirror_coord(cax, sw);
        ay  = mirror_coord(cay, sh);
        if (mode_reg)
        begin
            bx = wrap_coord(cbx, tw);
            by = wrap_coord(cby, th);
        end
        else
        begin
            bx = mirror_coord(cbx, tw);
            by = mirror_coord(cby, th);
        end
        pair_ok = (ax >= 0) && (ay >= 0) && (bx >= 0) && (by >= 0)
               && (ax < $signed({2'b00, sw})) && (ay < $signed({2'b00, sh}))
               && (bx < $signed({2'b00, tw})) && (by < $signed({2'b00, th}));
        src_raddr = {ay[COORD_W-1:0], ax[COORD_W-1:0]};
        tgt_raddr = {by[COORD_W-1:0], bx[COORD_W-1:0]};
    end

    logic [PIXEL_W-1:0] src_rdata, tgt_rdata;

    bssd_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_src_ram (
        .clk   (clk),
        .we    (cmd.we_src),
        .waddr ({source_y, source_x}),
        .wdata (pixel),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    bssd_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (cmd.we_tgt),
        .waddr ({target_y, target_x}),
        .wdata (pixel),
        .raddr (tgt_raddr),
        .rdata (tgt_rdata)
    );

    logic [15:0] sq [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [7:0] a, b, d;
            a     = src_rdata[8*k +: 8];
            b     = tgt_rdata[8*k +: 8];
            d     = (a > b) ? (a - b) : (b - a);
            sq[k] = d * d;
        end
    end

    // one restoring divide bit per cycle, channels in turn
    localparam logic [4:0] SUM_MSB = 5'(SUM_W - 1);
    logic [SUM_W-1:0]  sum_sel;
    logic [CNT_W:0]    rem_sh;
    logic              ge;
    logic [SUM_W-1:0]  quo_n;
    logic [CNT_W-1:0]  rem_n;
    always_comb
    begin
        sum_sel = sum_reg[chan_reg];
        rem_sh  = {rem_reg, sum_sel[SUM_MSB - bit_reg]};
        ge      = rem_sh >= {1'b0, cnt_reg};
        rem_n   = ge ? CNT_W'(rem_sh - {1'b0, cnt_reg}) : rem_sh[CNT_W-1:0];
        quo_n   = {quo_reg[SUM_W-2:0], ge};
    end

    logic [BEST_W-1:0] dist_now;
    logic [COORD_W:0]  ny, nx;
    assign dist_now = (cnt_reg == '0) ? '0 : total_reg;
    assign ny       = {1'b0, py_reg} + (COORD_W+1)'(step);
    assign nx       = {1'b0, px_reg} + (COORD_W+1)'(step);

    logic win_init;
    assign win_init = cmd.capture || (cmd.eval && !status.scan_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.win_step && pair_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tx_reg     <= target_x;
            ty_reg     <= target_y;
            search_reg <= is_search;
            err_reg    <= is_search ? !tgt_ok : !(tgt_ok && src_ok);
            best_reg   <= START_BEST;
            px_reg     <= is_search ? '0 : source_x;
            py_reg     <= is_search ? '0 : source_y;
            bx_reg     <= is_search ? '0 : source_x;
            by_reg     <= is_search ? '0 : source_y;
        end
        if (win_init)
        begin
            dx_reg    <= -r_s;
            dy_reg    <= -r_s;
            cnt_reg   <= '0;
            chan_reg  <= '0;
            bit_reg   <= '0;
            rem_reg   <= '0;
            total_reg <= '0;
            for (int k = 0; k < 4; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        if (cmd.win_step)
        begin
            if (dy_reg == r_s)
            begin
                dy_reg <= -r_s;
                dx_reg <= dx_reg + COORD_W'(1);
            end
            else
            begin
                dy_reg <= dy_reg + COORD_W'(1);
            end
        end
        if (v1_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            for (int k = 0; k < 4; k++)
            begin
                sum_reg[k] <= sum_reg[k] + SUM_W'(sq[k]);
            end
        end
        if (cmd.div_step)
        begin
            if (bit_reg == SUM_MSB)
            begin
                total_reg <= total_reg + quo_n[BEST_W-1:0];
                chan_reg  <= chan_reg + 2'd1;
                bit_reg   <= '0;
                rem_reg   <= '0;
            end
            else
            begin
                bit_reg <= bit_reg + 5'd1;
                rem_reg <= rem_n;
                quo_reg <= quo_n;
            end
        end
        if (cmd.eval)
        begin
            if (dist_now < best_reg)
            begin
                best_reg <= dist_now;
                bx_reg   <= px_reg;
                by_reg   <= py_reg;
            end
            if (ny >= (COORD_W+1)'(sh))
            begin
                py_reg <= '0;
                px_reg <= nx[COORD_W-1:0];
            end
            else
            begin
                py_reg <= ny[COORD_W-1:0];
            end
        end
    end

    assign status.in_err    = is_search ? !tgt_ok : !(tgt_ok && src_ok);
    assign status.win_last  = (dx_reg == r_s) && (dy_reg == r_s);
    assign status.div_done  = (chan_reg == 2'd3) && (bit_reg == SUM_MSB);
    assign status.scan_done = !search_reg
                           || ((ny >= (COORD_W+1)'(sh)) && (nx >= (COORD_W+1)'(sw)));
    assign status.out_free  = !out_valid || out_ready;

    // output register
    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    logic [DIST_W-1:0]  dist_out_reg;
    logic [COORD_W-1:0] mx_out_reg, my_out_reg;
    logic               err_out_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            dist_out_reg <= err_reg ? '0 : best_reg[DIST_W-1:0];
            mx_out_reg   <= bx_reg;
            my_out_reg   <= by_reg;
            err_out_reg  <= err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign distance    = dist_out_reg;
    assign match_x     = mx_out_reg;
    assign match_y     = my_out_reg;
    assign point_error = err_out_reg;

endmodule
`default_nettype wire

// ===== hdl/neighbourhood_ssd_best_match_unit.sv =====
`default_nettype none
// channel   dir  data                                          handshake
// s_axis    in   tdata 56b items, tuser action                 tvalid/tready
// m_axis    out  tdata 32b results, tuser point_error          tvalid/tready
// cfg       in   cfg_index/cfg_data register write             cfg_valid/cfg_ready
//
// Pixel loads are written from the idle state. A distance query walks the window,
// one window pair per cycle through the two pixel RAMs, drains, runs the
// shared bit-serial divider (28 bits x 4 channels) and compares.
// A search repeats these steps for each of ceil(sw/step) * ceil(sh/step) scanned
// positions, then loads the output.
// No input is taken while a query runs or while a finished result waits for a
// full output register. Reset clears control and configuration; RAMs are not cleared.
module neighbourhood_ssd_best_match_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // source_x, source_y, target_x, target_y, pixel
    input  wire logic [55:0]                        s_axis_tdata,
    // action
    input  wire logic [1:0]                         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // distance, match_x, match_y, zero pad
    output logic [31:0]                             m_axis_tdata,
    // point_error
    output logic [0:0]                              m_axis_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bssd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bssd_pkg::SIZE_W-1:0]        cfg_data
);
    import bssd_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic [DIST_W-1:0]  distance;
    logic [COORD_W-1:0] match_x, match_y;
    logic               point_error;

    assign cfg_ready = 1'b1;

    bssd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .action   (s_axis_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    bssd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .action      (s_axis_tuser),
        .source_x    (s_axis_tdata[5:0]),
        .source_y    (s_axis_tdata[11:6]),
        .target_x    (s_axis_tdata[17:12]),
        .target_y    (s_axis_tdata[23:18]),
        .pixel       (s_axis_tdata[55:24]),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .distance    (distance),
        .match_x     (match_x),
        .match_y     (match_y),
        .point_error (point_error)
    );

    assign m_axis_tdata = {2'b00, match_y, match_x, distance};
    assign m_axis_tuser = point_error;

endmodule
`default_nettype wire

// ===== tb/neighbourhood_ssd_best_match_unit_test.sv =====
`timescale 1ns / 1ps

import bssd_pkg::*;

typedef struct {
    logic [17:0] distance;
    logic [5:0]  match_x;
    logic [5:0]  match_y;
    logic        point_error;
} match_t;

class ssd_scoreboard;
    logic [31:0] src_img [4096];
    logic [31:0] tgt_img [4096];
    int unsigned cfg_val [6];
    match_t      expected_q [$];
    int          fails;
    int          n_dist, n_search, n_err;

    function new();
        cfg_val = '{32, 32, 32, 32, 2, 0};
        fails = 0;
        n_dist = 0;
        n_search = 0;
        n_err = 0;
    endfunction

    function void write_reg(cfg_index_t idx, int unsigned v);
        cfg_val[idx] = v;
    endfunction

    function int eff(int idx);
        if (cfg_val[idx] == 0)
        begin
            return 1;
        end
        if (cfg_val[idx] > 64)
        begin
            return 64;
        end
        return cfg_val[idx];
    endfunction

    function int fold(int c, int w);
        if (c < 0)
        begin
            return -c;
        end
        if (c >= w)
        begin
            return 2 * (w - 1) - c;
        end
        return c;
    endfunction

    function int wrap_around(int c, int w);
        if (c < 0)
        begin
            return c + w;
        end
        if (c >= w)
        begin
            return c - w;
        end
        return c;
    endfunction

    function int unsigned window_ssd(int sx, int sy, int tx, int ty);
        int sw, sh, tw, th, r, ax, ay, bx, by, a, b;
        int unsigned sum [4];
        int unsigned cnt, total;
        logic [31:0] pa, pb;
        sw = eff(REG_SRC_W);
        sh = eff(REG_SRC_H);
        tw = eff(REG_TGT_W);
        th = eff(REG_TGT_H);
        r = cfg_val[REG_RADIUS];
        sum = '{0, 0, 0, 0};
        cnt = 0;
        total = 0;
        for (int dx = -r; dx <= r; dx++)
        begin
            for (int dy = -r; dy <= r; dy++)
            begin
                ax = fold(sx + dx, sw);
                ay = fold(sy + dy, sh);
                if (cfg_val[REG_MODE] != 0)
                begin
                    bx = wrap_around(tx + dx, tw);
                    by = wrap_around(ty + dy, th);
                end
                else
                begin
                    bx = fold(tx + dx, tw);
                    by = fold(ty + dy, th);
                end
                if (ax < 0 || ay < 0 || ax >= sw || ay >= sh) continue;
                if (bx < 0 || by < 0 || bx >= tw || by >= th) continue;
                pa = src_img[ay * 64 + ax];
                pb = tgt_img[by * 64 + bx];
                for (int k = 0; k < 4; k++)
                begin
                    a = pa[8*k +: 8];
                    b = pb[8*k +: 8];
                    sum[k] += (a - b) * (a - b);
                end
                cnt++;
            end
        end
        if (cnt == 0)
        begin
            return 0;
        end
        for (int k = 0; k < 4; k++)
        begin
            total += sum[k] / cnt;
        end
        return total;
    endfunction

    function void note_item(action_t act, int sx, int sy, int tx, int ty, logic [31:0] pix);
        match_t m;
        int sw, sh, step;
        int unsigned best, d;
        bit tgt_ok;
        sw = eff(REG_SRC_W);
        sh = eff(REG_SRC_H);
        tgt_ok = tx < eff(REG_TGT_W) && ty < eff(REG_TGT_H);
        case (act)
            ACT_LOAD_SRC: src_img[sy * 64 + sx] = pix;
            ACT_LOAD_TGT: tgt_img[ty * 64 + tx] = pix;
            ACT_DISTANCE:
            begin
                n_dist++;
                m.match_x = sx;
                m.match_y = sy;
                m.point_error = !(tgt_ok && sx < sw && sy < sh);
                m.distance = m.point_error ? 18'd0 : 18'(window_ssd(sx, sy, tx, ty));
                n_err += m.point_error;
                expected_q.push_back(m);
            end
            default:
            begin
                n_search++;
                m = '{18'd0, 6'd0, 6'd0, 1'b1};
                if (tgt_ok)
                begin
                    step = (2 * cfg_val[REG_RADIUS] + 1) / 4;
                    if (step < 1) step = 1;
                    best = 1000000;
                    // first minimum in scan order, columns outer
                    for (int x = 0; x < sw; x += step)
                    begin
                        for (int y = 0; y < sh; y += step)
                        begin
                            d = window_ssd(x, y, tx, ty);
                            if (d < best)
                            begin
                                best = d;
                                m.match_x = x;
                                m.match_y = y;
                            end
                        end
                    end
                    m.distance = 18'(best);
                    m.point_error = 1'b0;
                end
                else
                begin
                    n_err++;
                end
                expected_q.push_back(m);
            end
        endcase
    endfunction

    function void check_result(logic [31:0] data, logic err);
        match_t m;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result item data=%h err=%b", data, err);
            fails++;
            return;
        end
        m = expected_q.pop_front();
        if (data[17:0] !== m.distance)
        begin
            $error("distance: expected %0d, got %0d", m.distance, data[17:0]);
            fails++;
        end
        if (data[23:18] !== m.match_x)
        begin
            $error("match_x: expected %0d, got %0d", m.match_x, data[23:18]);
            fails++;
        end
        if (data[29:24] !== m.match_y)
        begin
            $error("match_y: expected %0d, got %0d", m.match_y, data[29:24]);
            fails++;
        end
        if (err !== m.point_error)
        begin
            $error("point_error: expected %0d, got %0d", m.point_error, err);
            fails++;
        end
    endfunction
endclass

module neighbourhood_ssd_best_match_unit_test;

    localparam int IDLE_LIMIT = 200000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    ssd_scoreboard sb = new();
    bit  calm = 0;
    int  stall = 0;
    int  idle_cycles = 0;
    int  n_items = 0;
    int  n_phases = 0;

    neighbourhood_ssd_best_match_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (stall > 0)
        begin
            stall <= stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall <= $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no item moving on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(action_t act, int sx, int sy, int tx, int ty, logic [31:0] pix);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {pix, 6'(ty), 6'(tx), 6'(sy), 6'(sx)};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(act, sx, sy, tx, ty, pix);
        n_items++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(cfg_index_t idx, int unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= SIZE_W'(v);
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, v);
    endtask

    task automatic set_all(int sw, int sh, int tw, int th, int r, int mode);
        settle();
        write_reg(REG_SRC_W, sw);
        write_reg(REG_SRC_H, sh);
        write_reg(REG_TGT_W, tw);
        write_reg(REG_TGT_H, th);
        write_reg(REG_RADIUS, r);
        write_reg(REG_MODE, mode);
        cfg_valid <= 1'b0;
        n_phases++;
    endtask

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // every pixel a query can reach lies in the configured area
    task automatic fill();
        for (int y = 0; y < sb.eff(REG_SRC_H); y++)
            for (int x = 0; x < sb.eff(REG_SRC_W); x++)
                send(ACT_LOAD_SRC, x, y, $urandom_range(0, 63), $urandom_range(0, 63),
                     rand_pixel());
        for (int y = 0; y < sb.eff(REG_TGT_H); y++)
            for (int x = 0; x < sb.eff(REG_TGT_W); x++)
                send(ACT_LOAD_TGT, $urandom_range(0, 63), $urandom_range(0, 63), x, y,
                     rand_pixel());
    endtask

    function automatic int pick(int idx);
        if ($urandom_range(0, 6) == 0)
        begin
            return $urandom_range(0, 63);
        end
        return $urandom_range(0, sb.eff(idx) - 1);
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small images, mirrored edges on both sides
        set_all(4, 4, 4, 4, 1, 0);
        fill();
        send(ACT_DISTANCE, 0, 0, 0, 0, 0);
        send(ACT_DISTANCE, 3, 3, 3, 3, 0);
        send(ACT_DISTANCE, 0, 3, 3, 0, 32'hFFFF_FFFF);
        send(ACT_DISTANCE, 4, 0, 0, 0, 0);
        send(ACT_DISTANCE, 63, 63, 63, 63, 0);
        send(ACT_DISTANCE, 1, 1, 0, 63, 0);
        send(ACT_SEARCH, 0, 0, 2, 1, 0);
        send(ACT_SEARCH, 0, 0, 5, 0, 0);
        // pause until the block has drained
        settle();
        send(ACT_SEARCH, 0, 0, 3, 3, 0);

        // single pixel images, widest window, wrap around
        set_all(1, 1, 1, 1, 31, 1);
        fill();
        send(ACT_DISTANCE, 0, 0, 0, 0, 0);
        send(ACT_SEARCH, 0, 0, 0, 0, 0);
        send(ACT_DISTANCE, 0, 1, 0, 0, 0);

        // zero and oversized sizes
        set_all(127, 0, 64, 0, 31, 0);
        fill();
        send(ACT_DISTANCE, 63, 0, 0, 0, 0);
        send(ACT_SEARCH, 0, 0, 63, 0, 0);
        settle();
        write_reg(REG_RADIUS, 7);
        cfg_valid <= 1'b0;
        send(ACT_SEARCH, 0, 0, 40, 0, 0);
        send(ACT_DISTANCE, 10, 0, 62, 1, 0);

        while (n_items < 1600)
        begin
            if (n_items > 1400) calm = 1;
            set_all($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                    $urandom_range(1, 6), $urandom_range(0, 4), $urandom_range(0, 1));
            fill();
            repeat (100)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7:
                        send(action_t'($urandom_range(0, 1)), $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 63), rand_pixel());
                    8, 9:
                        send(ACT_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63),
                             pick(REG_TGT_W), pick(REG_TGT_H), $urandom);
                    default:
                        send(ACT_DISTANCE, pick(REG_SRC_W), pick(REG_SRC_H),
                             pick(REG_TGT_W), pick(REG_TGT_H), $urandom);
                endcase
            end
        end

        calm = 1;
        settle();
        repeat (100) @(posedge clk);
        $display("covered %0d items in %0d settings: %0d distance queries, %0d searches,",
                 n_items, n_phases, sb.n_dist, sb.n_search);
        $display("%0d of the queries with a point outside its image", sb.n_err);
        if (sb.fails == 0 && sb.expected_q.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
